// File: hw/rtl/prefix_request_rate_limiter_assert.svh
// Assertion macros for the prefix request rate limiter.
`ifndef PREFIX_REQUEST_RATE_LIMITER_ASSERT_SVH
`define PREFIX_REQUEST_RATE_LIMITER_ASSERT_SVH
`ifndef SYNTHESIS
`define PRRL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define PRRL_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (nxt)) else $error(msg);
`else
`define PRRL_ASSERT(lbl, prop, msg)
`define PRRL_ASSERT_NEXT(lbl, cond, nxt, msg)
`endif
`endif

// File: hw/rtl/prrl_pkg.sv
// Shared types, codes and helpers of the prefix request rate limiter.
`timescale 1ns / 1ps
package prrl_pkg;

    localparam int TABLE_ENTRIES_DEF  = 256;
    localparam int CLEAN_INTERVAL_DEF = 1024;

    // operation codes; the unused code acts as check
    localparam logic [1:0] OP_CHECK = 2'd0;
    localparam logic [1:0] OP_TYPE  = 2'd1;
    localparam logic [1:0] OP_RATIO = 2'd2;

    // configuration register indexes
    localparam logic [3:0] CFG_IPV4_LEN   = 4'd0;
    localparam logic [3:0] CFG_IPV6_LEN   = 4'd1;
    localparam logic [3:0] CFG_TYPE_LIM   = 4'd2;
    localparam logic [3:0] CFG_RATIO_LIM  = 4'd3;
    localparam logic [3:0] CFG_RATIO_THR  = 4'd4;
    localparam logic [3:0] CFG_PERIOD     = 4'd5;
    localparam logic [3:0] CFG_BLOCK_TIME = 4'd6;
    localparam logic [3:0] CFG_CLEAN_AGE  = 4'd7;

    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_CLN_RD,
        ST_CLN_CMP,
        ST_LK_RD,
        ST_LK_CMP,
        ST_LK_DONE,
        ST_DAT_RD,
        ST_DAT_LD,
        ST_DISPATCH,
        ST_DIV_GO,
        ST_DIV,
        ST_MUL,
        ST_UPD,
        ST_EVAL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic        v6;
        logic [63:0] up;
        logic [63:0] lo;
    } key_t;

    typedef struct packed {
        logic [31:0] types_cnt;
        logic [31:0] ratios_cnt;
        logic [47:0] stamp;
        logic        stamp_set;
        logic [47:0] dl;
        logic        dl_set;
        logic        mark;
    } rec_t;

    // leading-ones mask of a 64-bit word
    function automatic logic [63:0] lead_mask(input logic [7:0] bits);
        logic [63:0] m;
        for (int i = 0; i < 64; i++) begin
            m[63-i] = (8'(i) < bits);
        end
        return m;
    endfunction

endpackage

// File: hw/rtl/prefix_request_rate_limiter.sv
// Top level of the prefix request rate limiter.
//
//  channel | dir | handshake          | word
//  s_      | in  | s_tvalid/s_tready  | request: tdata 216 bits, tuser 3 bits
//  m_      | out | m_tvalid/m_tready  | verdict: tdata 8 bits
//  cfg_    | in  | cfg_valid/cfg_ready| register index 4 bits, data 32 bits
//
// One request at a time. A hit reads key entries up to the hit and then loads the
// record; an insert skips the record load; a full table reads all entries and ends.
// A check on a stamped entry adds a divider pass: start, 48 divider steps, done, scale.
// A cleaning request first walks the whole table.
// Reset clears the valid bits at once; no clearing pass. A stalled result
// holds in the output register while the next request is already taken.
`timescale 1ns / 1ps
`include "prefix_request_rate_limiter_assert.svh"
module prefix_request_rate_limiter #(
    parameter int TABLE_ENTRIES  = prrl_pkg::TABLE_ENTRIES_DEF,
    parameter int CLEAN_INTERVAL = prrl_pkg::CLEAN_INTERVAL_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // address_high[63:0], address_low[127:64], now_ms[175:128], may_clean[176],
    // type_listed[177], ratio_value[209:178], zero pad[215:210]
    input  logic [215:0] s_tdata,
    // operation[1:0], is_ipv6[2]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // blocked[0], table_full[1], zero pad[7:2]
    output logic [7:0]   m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [31:0] CLEAN_LIM = 32'(CLEAN_INTERVAL);

    // configuration
    logic [5:0]  ipv4_len_reg;
    logic [7:0]  ipv6_len_reg;
    logic [31:0] type_lim_reg, ratio_lim_reg, ratio_thr_reg;
    logic [31:0] period_reg, block_time_reg, clean_age_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ipv4_len_reg   <= 6'd24;
            ipv6_len_reg   <= 8'd56;
            type_lim_reg   <= 32'd100;
            ratio_lim_reg  <= 32'd100;
            ratio_thr_reg  <= 32'd65536;
            period_reg     <= 32'd1000;
            block_time_reg <= 32'd60000;
            clean_age_reg  <= 32'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                prrl_pkg::CFG_IPV4_LEN:   ipv4_len_reg   <= cfg_data[5:0];
                prrl_pkg::CFG_IPV6_LEN:   ipv6_len_reg   <= cfg_data[7:0];
                prrl_pkg::CFG_TYPE_LIM:   type_lim_reg   <= cfg_data;
                prrl_pkg::CFG_RATIO_LIM:  ratio_lim_reg  <= cfg_data;
                prrl_pkg::CFG_RATIO_THR:  ratio_thr_reg  <= cfg_data;
                prrl_pkg::CFG_PERIOD:     period_reg     <= cfg_data;
                prrl_pkg::CFG_BLOCK_TIME: block_time_reg <= cfg_data;
                prrl_pkg::CFG_CLEAN_AGE:  clean_age_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // state and working registers
    prrl_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, slot_reg;
    logic             found_reg, free_reg;
    logic [31:0]      clean_cnt_reg;
    logic             valid_reg [TABLE_ENTRIES];
    logic             out_valid_reg, out_blk_reg, out_full_reg;
    logic             blk_reg, full_reg;

    logic [1:0]       op_reg;
    logic             v6_reg, may_clean_reg, listed_reg;
    logic [63:0]      addr_hi_reg, addr_lo_reg;
    logic [47:0]      now_reg;
    logic [31:0]      ratio_reg;
    logic             count_reg, qual_reg, clean_go_reg;
    logic [41:0]      age_ms_reg;
    prrl_pkg::key_t   key_reg;
    prrl_pkg::rec_t   rec_reg;
    logic [63:0]      prod_t_reg, prod_r_reg;
    logic             q_big_reg;

    // memories
    prrl_pkg::key_t   key_mem [TABLE_ENTRIES];
    prrl_pkg::rec_t   rec_mem [TABLE_ENTRIES];
    prrl_pkg::key_t   key_q;
    prrl_pkg::rec_t   rec_q;
    logic [IDX_W-1:0] rec_raddr;

    // control strobes
    logic key_we, rec_we, ins_set, clean_clr, div_start;
    logic out_free, clean_hit, key_hit;

    // datapath helpers
    prrl_pkg::key_t key_calc;
    prrl_pkg::rec_t rec_eval;
    logic           div_done;
    logic [47:0]    div_q, elapsed;
    logic [31:0]    divisor;
    logic [31:0]    t_dec, r_dec;
    logic           res;
    logic [48:0]    dl_sum;

    // prefix truncation
    always_comb begin
        logic [7:0]  p6;
        logic [5:0]  p4;
        logic [63:0] mu, ml, m4;
        p6 = (ipv6_len_reg > 8'd128) ? 8'd128 : ipv6_len_reg;
        p4 = (ipv4_len_reg > 6'd32) ? 6'd32 : ipv4_len_reg;
        mu = prrl_pkg::lead_mask(p6);
        ml = prrl_pkg::lead_mask((p6 > 8'd64) ? p6 - 8'd64 : 8'd0);
        m4 = prrl_pkg::lead_mask({2'b00, p4});
        key_calc.v6 = v6_reg;
        if (v6_reg) begin
            key_calc.up = addr_hi_reg & mu;
            key_calc.lo = addr_lo_reg & ml;
        end else begin
            key_calc.up = '0;
            key_calc.lo = {32'd0, addr_lo_reg[31:0] & m4[63:32]};
        end
    end

    // memory ports, registered reads
    assign rec_raddr = (state_reg == prrl_pkg::ST_CLN_RD) ? idx_reg : slot_reg;

    always_ff @(posedge aclk) begin
        key_q <= key_mem[idx_reg];
        rec_q <= rec_mem[rec_raddr];
        if (key_we) begin
            key_mem[slot_reg] <= key_reg;
        end
        if (rec_we) begin
            rec_mem[slot_reg] <= rec_eval;
        end
    end

    assign key_hit   = valid_reg[idx_reg] && (key_q == key_reg);
    assign clean_hit = valid_reg[idx_reg] && rec_q.stamp_set &&
                       (({1'b0, rec_q.stamp} + 49'(age_ms_reg)) < {1'b0, now_reg});
    assign out_free  = !out_valid_reg || m_tready;

    // decay step count
    assign elapsed = (now_reg > rec_reg.stamp) ? now_reg - rec_reg.stamp : 48'd0;
    assign divisor = (period_reg == 32'd0) ? 32'd1 : period_reg;

    prrl_div #(
        .DW(48),
        .VW(32)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (elapsed),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // decayed counters
    always_comb begin
        if (q_big_reg && type_lim_reg != 32'd0) begin
            t_dec = '0;
        end else begin
            t_dec = ({32'd0, rec_reg.types_cnt} > prod_t_reg) ?
                    32'({32'd0, rec_reg.types_cnt} - prod_t_reg) : 32'd0;
        end
        if (q_big_reg && ratio_lim_reg != 32'd0) begin
            r_dec = '0;
        end else begin
            r_dec = ({32'd0, rec_reg.ratios_cnt} > prod_r_reg) ?
                    32'({32'd0, rec_reg.ratios_cnt} - prod_r_reg) : 32'd0;
        end
    end

    // block evaluation and write-back record
    always_comb begin
        res = (rec_reg.ratios_cnt > ratio_lim_reg) || (rec_reg.types_cnt > type_lim_reg) ||
              (rec_reg.dl_set && now_reg <= rec_reg.dl);
        dl_sum   = {1'b0, now_reg} + {17'd0, block_time_reg};
        rec_eval = rec_reg;
        if (state_reg == prrl_pkg::ST_EVAL) begin
            if (res && !rec_reg.mark) begin
                rec_eval.dl     = dl_sum[48] ? prrl_pkg::MAX48 : dl_sum[47:0];
                rec_eval.dl_set = 1'b1;
            end
            if (count_reg) begin
                rec_eval.mark = res;
            end else if (!res) begin
                rec_eval.mark = 1'b0;
            end
        end else begin
            rec_eval = '0;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            prrl_pkg::ST_IDLE:     if (s_tvalid) state_next = prrl_pkg::ST_PREP;
            prrl_pkg::ST_PREP:     state_next = prrl_pkg::ST_DISPATCH;
            prrl_pkg::ST_CLN_RD:   state_next = prrl_pkg::ST_CLN_CMP;
            prrl_pkg::ST_CLN_CMP:
                state_next = (idx_reg == LAST) ? prrl_pkg::ST_LK_RD : prrl_pkg::ST_CLN_RD;
            prrl_pkg::ST_LK_RD:    state_next = prrl_pkg::ST_LK_CMP;
            prrl_pkg::ST_LK_CMP:
                state_next = (key_hit || idx_reg == LAST) ?
                             prrl_pkg::ST_LK_DONE : prrl_pkg::ST_LK_RD;
            prrl_pkg::ST_LK_DONE: begin
                if (found_reg) state_next = prrl_pkg::ST_DAT_RD;
                else if (free_reg) state_next = prrl_pkg::ST_DISPATCH;
                else state_next = prrl_pkg::ST_FINISH;
            end
            prrl_pkg::ST_DAT_RD:   state_next = prrl_pkg::ST_DAT_LD;
            prrl_pkg::ST_DAT_LD:   state_next = prrl_pkg::ST_DISPATCH;
            prrl_pkg::ST_DISPATCH: begin
                // entered twice: after setup (route to scans) and after load or insert
                if (!found_reg && !free_reg) begin
                    state_next = clean_go_reg ? prrl_pkg::ST_CLN_RD : prrl_pkg::ST_LK_RD;
                end else if (count_reg) begin
                    state_next = qual_reg ? prrl_pkg::ST_UPD : prrl_pkg::ST_FINISH;
                end else begin
                    state_next = rec_reg.stamp_set ? prrl_pkg::ST_DIV_GO : prrl_pkg::ST_FINISH;
                end
            end
            prrl_pkg::ST_DIV_GO:   state_next = prrl_pkg::ST_DIV;
            prrl_pkg::ST_DIV:      if (div_done) state_next = prrl_pkg::ST_MUL;
            prrl_pkg::ST_MUL:      state_next = prrl_pkg::ST_UPD;
            prrl_pkg::ST_UPD:      state_next = prrl_pkg::ST_EVAL;
            prrl_pkg::ST_EVAL:     state_next = prrl_pkg::ST_FINISH;
            prrl_pkg::ST_FINISH:   if (out_free) state_next = prrl_pkg::ST_IDLE;
            default:               state_next = prrl_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready  = 1'b0;
        key_we    = 1'b0;
        rec_we    = 1'b0;
        ins_set   = 1'b0;
        clean_clr = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            prrl_pkg::ST_IDLE:    s_tready = 1'b1;
            prrl_pkg::ST_CLN_CMP: clean_clr = clean_hit;
            prrl_pkg::ST_LK_DONE: begin
                // an insert also writes a cleared record
                key_we  = !found_reg && free_reg;
                rec_we  = !found_reg && free_reg;
                ins_set = !found_reg && free_reg;
            end
            prrl_pkg::ST_DIV_GO:  div_start = 1'b1;
            prrl_pkg::ST_EVAL:    rec_we = 1'b1;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= prrl_pkg::ST_IDLE;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            clean_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg <= state_next;
            // output word: loaded on finish, cleared when taken
            if (state_reg == prrl_pkg::ST_FINISH && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                prrl_pkg::ST_PREP: begin
                    found_reg <= 1'b0;
                    free_reg  <= 1'b0;
                    idx_reg   <= '0;
                    if (may_clean_reg && clean_age_reg != 32'd0) begin
                        clean_cnt_reg <= (clean_cnt_reg + 32'd1 >= CLEAN_LIM) ?
                                         32'd0 : clean_cnt_reg + 32'd1;
                    end
                end
                prrl_pkg::ST_CLN_CMP: begin
                    if (clean_hit) valid_reg[idx_reg] <= 1'b0;
                    idx_reg <= (idx_reg == LAST) ? '0 : idx_reg + 1'b1;
                end
                prrl_pkg::ST_LK_CMP: begin
                    if (key_hit) begin
                        found_reg <= 1'b1;
                    end else begin
                        if (!valid_reg[idx_reg] && !free_reg) free_reg <= 1'b1;
                        if (idx_reg != LAST) idx_reg <= idx_reg + 1'b1;
                    end
                end
                prrl_pkg::ST_LK_DONE: begin
                    if (ins_set) valid_reg[slot_reg] <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg        <= s_tuser[1:0];
            v6_reg        <= s_tuser[2];
            addr_hi_reg   <= s_tdata[63:0];
            addr_lo_reg   <= s_tdata[127:64];
            now_reg       <= s_tdata[175:128];
            may_clean_reg <= s_tdata[176];
            listed_reg    <= s_tdata[177];
            ratio_reg     <= s_tdata[209:178];
        end
        case (state_reg)
            prrl_pkg::ST_PREP: begin
                key_reg      <= key_calc;
                count_reg    <= (op_reg == prrl_pkg::OP_TYPE) || (op_reg == prrl_pkg::OP_RATIO);
                qual_reg     <= (op_reg == prrl_pkg::OP_TYPE) ? listed_reg :
                                (ratio_reg >= ratio_thr_reg);
                age_ms_reg   <= 42'(clean_age_reg) * 42'd1000;
                clean_go_reg <= may_clean_reg && clean_age_reg != 32'd0 &&
                                (clean_cnt_reg + 32'd1 >= CLEAN_LIM);
                blk_reg      <= 1'b0;
                full_reg     <= 1'b0;
            end
            prrl_pkg::ST_LK_CMP: begin
                if (key_hit || (!valid_reg[idx_reg] && !free_reg)) slot_reg <= idx_reg;
            end
            prrl_pkg::ST_LK_DONE: begin
                rec_reg  <= '0;
                full_reg <= !found_reg && !free_reg;
            end
            prrl_pkg::ST_DAT_LD: rec_reg <= rec_q;
            prrl_pkg::ST_MUL: begin
                prod_t_reg <= 64'(div_q[31:0]) * 64'(type_lim_reg);
                prod_r_reg <= 64'(div_q[31:0]) * 64'(ratio_lim_reg);
                q_big_reg  <= |div_q[47:32];
            end
            prrl_pkg::ST_UPD: begin
                if (count_reg) begin
                    if (op_reg == prrl_pkg::OP_TYPE) begin
                        if (rec_reg.types_cnt != prrl_pkg::MAX32)
                            rec_reg.types_cnt <= rec_reg.types_cnt + 32'd1;
                    end else if (rec_reg.ratios_cnt != prrl_pkg::MAX32) begin
                        rec_reg.ratios_cnt <= rec_reg.ratios_cnt + 32'd1;
                    end
                    rec_reg.stamp     <= now_reg;
                    rec_reg.stamp_set <= 1'b1;
                end else begin
                    rec_reg.types_cnt  <= t_dec;
                    rec_reg.ratios_cnt <= r_dec;
                end
            end
            prrl_pkg::ST_EVAL: blk_reg <= rec_eval.mark;
            prrl_pkg::ST_FINISH: begin
                if (out_free) begin
                    out_blk_reg  <= blk_reg;
                    out_full_reg <= full_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_full_reg, out_blk_reg};

    `PRRL_ASSERT(a_full_not_blocked, m_tvalid |-> !(m_tdata[0] && m_tdata[1]), "full verdict marked blocked")
    `PRRL_ASSERT_NEXT(a_accept_prep, s_tvalid && s_tready, state_reg == prrl_pkg::ST_PREP, "accept did not start setup")
    `PRRL_ASSERT(a_div_in_state, div_done |-> (state_reg == prrl_pkg::ST_DIV), "divider finished outside wait")
    `PRRL_ASSERT(a_one_valid_write, !(clean_clr && ins_set), "two valid-bit writes at once")
    `PRRL_ASSERT_NEXT(a_insert_hit, ins_set, found_reg == 1'b0 && full_reg == 1'b0, "insert with hit or full table")
endmodule

// File: hw/rtl/prrl_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module prrl_div #(
    parameter int DW = 48,
    parameter int VW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CW = $clog2(DW);

    logic [DW-1:0] dq_reg, dq_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [VW:0]   rem_w;
    logic          ge;

    // one shift-subtract step
    always_comb begin
        rem_w    = {rem_reg, dq_reg[DW-1]};
        ge       = rem_w >= {1'b0, dvs_reg};
        rem_next = ge ? VW'(rem_w - {1'b0, dvs_reg}) : rem_w[VW-1:0];
        dq_next  = {dq_reg[DW-2:0], ge};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operands
    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;
endmodule

// File: verif/testbench.sv
// Self-checking testbench for the prefix request rate limiter.
`timescale 1ns / 1ps
module testbench;

    localparam int SLOTS    = 256;
    localparam int CLEAN_N  = 1024;
    localparam int SETTLE   = 1500;  // covers a cleaning walk plus a full-table miss
    localparam int N_POOL   = 24;
    localparam int N_ROWS   = 12;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        v6;
        logic [47:0] now;
        logic        clean;
        logic        listed;
        logic [31:0] ratio;
    } req_t;

    typedef struct packed {
        logic blocked;
        logic full;
    } verdict_t;

    typedef struct packed {
        req_t     rq;
        logic     typed;
        verdict_t want;
    } row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [215:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [3:0]   cfg_index;
    logic [31:0]  cfg_data;

    prefix_request_rate_limiter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // mirror of the block configuration
    logic [5:0]  len_v4;
    logic [7:0]  len_v6;
    logic [31:0] lim_type, lim_ratio, ratio_thr, period_ms, hold_ms, age_s;

    // mirror of the prefix table
    logic        slot_used [SLOTS];
    logic [63:0] slot_up   [SLOTS];
    logic [63:0] slot_lo   [SLOTS];
    logic        slot_v6   [SLOTS];
    logic [31:0] type_cnt  [SLOTS];
    logic [31:0] ratio_cnt [SLOTS];
    logic [47:0] stamp     [SLOTS];
    logic        stamp_ok  [SLOTS];
    logic [47:0] unblock_at[SLOTS];
    logic        unblock_ok[SLOTS];
    logic        blk_mark  [SLOTS];
    logic [31:0] since_clean;

    verdict_t    pending_verdicts[$];
    int          fail_count = 0;
    int          send_pct = 0, recv_pct = 0, hold_left = 0;
    int          n_sent = 0, n_blocked = 0, n_full = 0, n_cleans = 0;
    logic [47:0] clock_ms = 48'd0;
    logic [63:0] pool_hi[N_POOL];
    logic [63:0] pool_lo[N_POOL];
    logic        pool_v6[N_POOL];

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(250_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [63:0] keep_mask(int unsigned bits);
        if (bits == 0) return 64'd0;
        if (bits >= 64) return '1;
        return ~64'd0 << (64 - bits);
    endfunction

    function automatic logic [31:0] decay_cnt(logic [31:0] c, logic [47:0] steps,
                                              logic [31:0] lim);
        logic [63:0] dec;
        if (steps == 0 || lim == 0) return c;
        if (steps > 48'(prrl_pkg::MAX32)) return 32'd0;
        dec = 64'(steps) * 64'(lim);
        return (64'(c) > dec) ? c - dec[31:0] : 32'd0;
    endfunction

    // block condition; arms the deadline when the entry becomes blocked
    function automatic logic block_holds(int e, logic [47:0] now);
        logic       res;
        logic [48:0] d;
        res = (ratio_cnt[e] > lim_ratio) || (type_cnt[e] > lim_type);
        if (unblock_ok[e] && now <= unblock_at[e]) res = 1'b1;
        if (res && !blk_mark[e]) begin
            d = 49'(now) + 49'(hold_ms);
            unblock_at[e] = d[48] ? prrl_pkg::MAX48 : d[47:0];
            unblock_ok[e] = 1'b1;
        end
        return res;
    endfunction

    // expected verdict of one accepted request; updates the table mirror
    function automatic verdict_t rate_verdict(req_t r);
        verdict_t    v;
        logic [63:0] up, lo, age, m;
        logic [47:0] elapsed, steps;
        logic [31:0] per;
        int unsigned p;
        int          slot;
        logic        found, got_free, qual;
        v = '0;
        if (r.v6) begin
            p  = (len_v6 > 128) ? 128 : len_v6;
            up = r.hi & keep_mask(p);
            lo = r.lo & keep_mask(p > 64 ? p - 64 : 0);
        end else begin
            p  = (len_v4 > 32) ? 32 : len_v4;
            m  = keep_mask(p) >> 32;
            up = 64'd0;
            lo = {32'd0, r.lo[31:0] & m[31:0]};
        end
        if (r.clean && age_s != 0) begin
            since_clean = since_clean + 32'd1;
            if (since_clean >= CLEAN_N) begin
                since_clean = 32'd0;
                n_cleans++;
                age = 64'(age_s) * 64'd1000;
                for (int e = 0; e < SLOTS; e++)
                    if (slot_used[e] && stamp_ok[e] && 64'(stamp[e]) + age < 64'(r.now))
                        slot_used[e] = 1'b0;
            end
        end
        found = 1'b0; got_free = 1'b0; slot = 0;
        for (int e = 0; e < SLOTS && !found; e++) begin
            if (slot_used[e]) begin
                if (slot_v6[e] == r.v6 && slot_up[e] == up && slot_lo[e] == lo) begin
                    slot = e; found = 1'b1;
                end
            end else if (!got_free) begin
                slot = e; got_free = 1'b1;
            end
        end
        if (!found) begin
            if (!got_free) begin
                v.full = 1'b1;
                return v;
            end
            slot_used[slot] = 1'b1; slot_v6[slot] = r.v6; slot_up[slot] = up;
            slot_lo[slot] = lo; type_cnt[slot] = 32'd0; ratio_cnt[slot] = 32'd0;
            stamp_ok[slot] = 1'b0; unblock_ok[slot] = 1'b0; blk_mark[slot] = 1'b0;
        end
        if (r.op == prrl_pkg::OP_TYPE || r.op == prrl_pkg::OP_RATIO) begin
            qual = (r.op == prrl_pkg::OP_TYPE) ? r.listed : (r.ratio >= ratio_thr);
            if (qual) begin
                if (r.op == prrl_pkg::OP_TYPE) begin
                    if (type_cnt[slot] != prrl_pkg::MAX32) type_cnt[slot]++;
                end else if (ratio_cnt[slot] != prrl_pkg::MAX32) begin
                    ratio_cnt[slot]++;
                end
                stamp[slot] = r.now;
                stamp_ok[slot] = 1'b1;
                blk_mark[slot] = block_holds(slot, r.now);
                v.blocked = blk_mark[slot];
            end
        end else if (stamp_ok[slot]) begin
            // check: decay both counters, then re-evaluate
            per = (period_ms == 0) ? 32'd1 : period_ms;
            elapsed = (r.now > stamp[slot]) ? r.now - stamp[slot] : 48'd0;
            steps = elapsed / 48'(per);
            ratio_cnt[slot] = decay_cnt(ratio_cnt[slot], steps, lim_ratio);
            type_cnt[slot] = decay_cnt(type_cnt[slot], steps, lim_type);
            if (!block_holds(slot, r.now)) blk_mark[slot] = 1'b0;
            v.blocked = blk_mark[slot];
        end
        return v;
    endfunction

    task automatic write_reg(logic [3:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1; cfg_index = idx; cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            prrl_pkg::CFG_IPV4_LEN:   len_v4 = val[5:0];
            prrl_pkg::CFG_IPV6_LEN:   len_v6 = val[7:0];
            prrl_pkg::CFG_TYPE_LIM:   lim_type = val;
            prrl_pkg::CFG_RATIO_LIM:  lim_ratio = val;
            prrl_pkg::CFG_RATIO_THR:  ratio_thr = val;
            prrl_pkg::CFG_PERIOD:     period_ms = val;
            prrl_pkg::CFG_BLOCK_TIME: hold_ms = val;
            prrl_pkg::CFG_CLEAN_AGE:  age_s = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // leaves s_tvalid high so back-to-back words need no dead cycle
    task automatic send_req(req_t r, logic typed, verdict_t want);
        verdict_t v;
        @(negedge aclk);
        while ($urandom_range(99) < send_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {6'd0, r.ratio, r.listed, r.clean, r.now, r.lo, r.hi};
        s_tuser  = {r.v6, r.op};
        do @(posedge aclk); while (!s_tready);
        v = rate_verdict(r);
        pending_verdicts.insert(pending_verdicts.size(), typed ? want : v);
        n_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // random request: a pool client or, at fresh_pct percent, a fresh one, so counters build up
    function automatic req_t rand_req(int fresh_pct, int clean_pct, int max_step);
        req_t r;
        int   k;
        r.op = 2'($urandom_range(3));
        if ($urandom_range(99) < fresh_pct) begin
            r.hi = {$urandom, $urandom}; r.lo = {$urandom, $urandom};
            r.v6 = 1'($urandom_range(1));
        end else begin
            k = $urandom_range(N_POOL - 1);
            r.hi = pool_hi[k]; r.lo = pool_lo[k] ^ 64'($urandom_range(3)); r.v6 = pool_v6[k];
        end
        case ($urandom_range(99))
            0:       clock_ms = 48'({$urandom, $urandom});
            1, 2:    clock_ms = clock_ms - 48'($urandom_range(5000));
            default: clock_ms = clock_ms + 48'($urandom_range(max_step));
        endcase
        r.now    = clock_ms;
        r.clean  = ($urandom_range(99) < clean_pct);
        r.listed = ($urandom_range(99) < 80);
        case ($urandom_range(3))
            0:       r.ratio = $urandom;
            1:       r.ratio = ratio_thr - 32'($urandom_range(1));
            default: r.ratio = ratio_thr + 32'($urandom_range(2));
        endcase
        return r;
    endfunction

    function automatic row_t mk(logic [1:0] op, logic [63:0] hi, logic [63:0] lo,
                                logic v6, logic [47:0] now, logic [31:0] ratio,
                                logic listed, logic typed);
        row_t t;
        t.rq = '{op: op, hi: hi, lo: lo, v6: v6, now: now, clean: 1'b1,
                 listed: listed, ratio: ratio};
        t.typed = typed;
        t.want = '0;
        return t;
    endfunction

    // receiver: random back-pressure plus an optional long hold
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                m_tready = ($urandom_range(99) >= recv_pct);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        verdict_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                $error("verdict word with nothing expected: %h", m_tdata);
                fail_count++;
            end else begin
                w = pending_verdicts.pop_front();
                if (m_tdata[0] !== w.blocked) begin
                    $error("blocked: expected %0b, got %0b", w.blocked, m_tdata[0]);
                    fail_count++;
                end
                if (m_tdata[1] !== w.full) begin
                    $error("table_full: expected %0b, got %0b", w.full, m_tdata[1]);
                    fail_count++;
                end
                if (m_tdata[0]) n_blocked++;
                if (m_tdata[1]) n_full++;
            end
        end
    end

    initial begin
        row_t rows[N_ROWS];
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        len_v4 = 6'd24; len_v6 = 8'd56; lim_type = 32'd100; lim_ratio = 32'd100;
        ratio_thr = 32'h1_0000; period_ms = 32'd1000; hold_ms = 32'd60000; age_s = 32'd0;
        since_clean = 32'd0;
        for (int e = 0; e < SLOTS; e++) begin
            slot_used[e] = 1'b0; stamp_ok[e] = 1'b0; unblock_ok[e] = 1'b0;
            blk_mark[e] = 1'b0;
        end
        for (int k = 0; k < N_POOL; k++) begin
            pool_hi[k] = {$urandom, $urandom};
            pool_lo[k] = {$urandom, $urandom};
            pool_v6[k] = k[0];
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed part under reset configuration
        rows[0]  = mk(prrl_pkg::OP_CHECK, 64'd0, 64'h0A01_0203, 1'b0, 48'd0, 32'd0,
                      1'b0, 1'b1);
        rows[1]  = mk(prrl_pkg::OP_TYPE, 64'd0, 64'h0A01_0203, 1'b0, 48'd1, 32'd0,
                      1'b0, 1'b1);
        rows[2]  = mk(prrl_pkg::OP_TYPE, 64'd0, 64'h0A01_0203, 1'b0, 48'd5, 32'd0,
                      1'b1, 1'b1);
        rows[3]  = mk(prrl_pkg::OP_RATIO, 64'd0, 64'h0A01_02FF, 1'b0, 48'd6, 32'h1_0000,
                      1'b0, 1'b1);
        rows[4]  = mk(prrl_pkg::OP_RATIO, 64'd0, 64'h0A01_0203, 1'b0, 48'd7, 32'hFFFF,
                      1'b1, 1'b1);
        rows[5]  = mk(2'd3, 64'd0, 64'h0A01_0203, 1'b0, 48'd10, 32'd0, 1'b0, 1'b1);
        rows[6]  = mk(prrl_pkg::OP_TYPE, '1, '1, 1'b1, prrl_pkg::MAX48, prrl_pkg::MAX32,
                      1'b1, 1'b1);
        rows[7]  = mk(prrl_pkg::OP_CHECK, '1, 64'd0, 1'b1, 48'd0, 32'd0, 1'b0, 1'b1);
        rows[8]  = mk(prrl_pkg::OP_CHECK, 64'd0, 64'd0, 1'b0, 48'd0, 32'd0, 1'b0, 1'b1);
        rows[9]  = mk(prrl_pkg::OP_RATIO, '1, 64'd0, 1'b0, 48'd3000, prrl_pkg::MAX32,
                      1'b1, 1'b0);
        rows[10] = mk(prrl_pkg::OP_CHECK, 64'd0, 64'h0A01_0203, 1'b0, 48'd2500, 32'd0,
                      1'b0, 1'b0);
        rows[11] = mk(prrl_pkg::OP_CHECK, 64'd0, 64'hFFFF_FFFF_0A01_0203, 1'b0, 48'd9,
                      32'd0, 1'b0, 1'b0);
        foreach (rows[i]) send_req(rows[i].rq, rows[i].typed, rows[i].want);
        drain();

        // tight limits, short prefixes, long receiver hold
        write_reg(prrl_pkg::CFG_IPV4_LEN, 32'd0);
        write_reg(prrl_pkg::CFG_IPV6_LEN, 32'd48);
        write_reg(prrl_pkg::CFG_TYPE_LIM, 32'd3);
        write_reg(prrl_pkg::CFG_RATIO_LIM, 32'd2);
        write_reg(prrl_pkg::CFG_RATIO_THR, 32'h8000);
        write_reg(prrl_pkg::CFG_PERIOD, 32'd50);
        write_reg(prrl_pkg::CFG_BLOCK_TIME, 32'd200);
        send_pct = 12; recv_pct = 86; hold_left = 600;
        repeat (400) send_req(rand_req(5, 50, 30), 1'b0, '0);
        drain();

        // zero limits, full-length prefixes, zero period, cleaning on
        write_reg(prrl_pkg::CFG_IPV4_LEN, 32'd32);
        write_reg(prrl_pkg::CFG_IPV6_LEN, 32'd128);
        write_reg(prrl_pkg::CFG_TYPE_LIM, 32'd0);
        write_reg(prrl_pkg::CFG_RATIO_LIM, 32'd0);
        write_reg(prrl_pkg::CFG_RATIO_THR, prrl_pkg::MAX32);
        write_reg(prrl_pkg::CFG_PERIOD, 32'd0);
        write_reg(prrl_pkg::CFG_BLOCK_TIME, prrl_pkg::MAX32);
        write_reg(prrl_pkg::CFG_CLEAN_AGE, 32'd1);
        send_pct = 86; recv_pct = 12;
        repeat (550) send_req(rand_req(10, 95, 400), 1'b0, '0);
        drain();

        // maximal limits, oversized prefixes, table filling and age cleaning
        write_reg(prrl_pkg::CFG_IPV4_LEN, 32'd63);
        write_reg(prrl_pkg::CFG_IPV6_LEN, 32'd200);
        write_reg(prrl_pkg::CFG_TYPE_LIM, prrl_pkg::MAX32);
        write_reg(prrl_pkg::CFG_RATIO_LIM, prrl_pkg::MAX32);
        write_reg(prrl_pkg::CFG_RATIO_THR, 32'd0);
        write_reg(prrl_pkg::CFG_PERIOD, prrl_pkg::MAX32);
        write_reg(prrl_pkg::CFG_BLOCK_TIME, 32'd0);
        write_reg(prrl_pkg::CFG_CLEAN_AGE, 32'd2);
        send_pct = 0; recv_pct = 0;
        repeat (940) send_req(rand_req(60, 95, 150), 1'b0, '0);
        drain();

        $display("Sent %0d requests over four configurations, %0d age cleanings.",
                 n_sent, n_cleans);
        $display("Verdicts seen: %0d blocked, %0d table full.", n_blocked, n_full);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/prrl_pkg.sv
hw/rtl/prrl_div.sv
hw/rtl/prefix_request_rate_limiter.sv
verif/testbench.sv
